// File: rtl/idxfl_pkg.sv
// package for the index free list: types, field widths and codes
`default_nettype none

package idxfl_pkg;

    localparam int DEPTH_DEFAULT = 256;
    localparam int INDEX_W       = 8;
    localparam int ENTRY_COUNT_W = 9;
    localparam int CFG_DATA_W    = 9;
    localparam int CFG_INDEX_W   = 1;

    localparam logic [ENTRY_COUNT_W-1:0] ENTRY_COUNT_RESET = 9'd256;
    localparam logic                     START_FULL_RESET  = 1'b1;

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_ENTRY_COUNT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_FULL  = 1'b1;

    typedef enum logic [1:0] {
        OP_POP    = 2'd0,
        OP_PUSH   = 2'd1,
        OP_REINIT = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_FILL
    } state_t;

    typedef struct packed {
        op_t                operation;
        logic [INDEX_W-1:0] index;
    } req_item_t;

    typedef struct packed {
        logic [INDEX_W-1:0] popped_index;
        logic               ok;
    } rsp_item_t;

endpackage

`default_nettype wire

// File: rtl/index_free_list.sv
// top level of the index free list: link memory, head register and control
//
// a lifo pool of entry indices; the links sit in a synchronous memory, one
// link per entry, and a head register holds the first free index
// req channel (valid/ready): one transaction carries an operation and an
// index; pop hands out the head, push returns an index, reinit rebuilds
// rsp channel (valid/ready): one transaction per request, registered, seen
// the cycle after the request is taken
// steps per request, set by the registered link memory read and its single
// write port:
//   push, failed pop, empty reinit, unknown operation: handled in idle
//   successful pop: link read in idle, then head load in ST_POP
//   reinit in fill mode: ST_FILL writes n links, one link per cycle,
//   n = min(entry_count, DEPTH)
// a new request is taken only while the control is idle and the response
// register is empty or being drained in the same cycle; a stalled receiver
// therefore holds off the request side after one pending response
// reset empties the list (head at the null value DEPTH) and loads
// entry_count = 256, start_full = 1; the link memory is not cleared, so a
// reinit or pushes must build the list first
// config writes take effect at once and are meant for an idle block
`default_nettype none

module index_free_list #(
    parameter int DEPTH = idxfl_pkg::DEPTH_DEFAULT
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    // configuration write port
    input  wire                                   config_write,
    input  wire  [idxfl_pkg::CFG_INDEX_W-1:0]     config_index,
    input  wire  [idxfl_pkg::CFG_DATA_W-1:0]      config_data,
    // request channel
    input  wire                                   req_valid,
    output logic                                  req_ready,
    input  idxfl_pkg::req_item_t                  req,
    // response channel
    output logic                                  rsp_valid,
    input  wire                                   rsp_ready,
    output idxfl_pkg::rsp_item_t                  rsp
);

    import idxfl_pkg::*;

    // link width holds 0..DEPTH, DEPTH itself being the null link
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int LINK_W = $clog2(DEPTH + 1);
    // common width for comparing counts, indices and links
    localparam int CMP_W  = (LINK_W > ENTRY_COUNT_W) ? LINK_W : ENTRY_COUNT_W;

    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(DEPTH);
    localparam logic [CMP_W-1:0]  DEPTH_CMP = CMP_W'(DEPTH);

    // link memory, one link per entry, one read and one write port
    logic [LINK_W-1:0] link_mem [DEPTH];

    logic [LINK_W-1:0] rd_data_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [LINK_W-1:0] mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;

    // control and list state
    state_t                   state_reg, state_next;
    logic [LINK_W-1:0]        head_reg, head_next;
    logic [ADDR_W-1:0]        fill_idx_reg, fill_idx_next;
    logic [ADDR_W-1:0]        fill_last_reg, fill_last_next;
    logic [ENTRY_COUNT_W-1:0] entry_count_reg;
    logic                     start_full_reg;

    // response register
    logic       rsp_valid_reg, rsp_valid_next;
    rsp_item_t  rsp_reg, rsp_next;

    // derived values
    logic              req_fire;
    logic              head_ok;
    logic [CMP_W-1:0]  entry_count_cmp;
    logic [CMP_W-1:0]  active_cmp;
    logic [CMP_W-1:0]  index_cmp;
    logic              push_ok;
    logic              fill_go;
    logic              fill_end;
    logic [LINK_W-1:0] link_loaded;

    // low bits of the head as a handed-out index
    function automatic logic [INDEX_W-1:0] index_of_head(input logic [LINK_W-1:0] h);
        logic [CMP_W-1:0] wide;
        wide = CMP_W'(h);
        return wide[INDEX_W-1:0];
    endfunction

    assign req_fire        = req_valid && req_ready;
    assign head_ok         = (head_reg < NULL_LINK);
    assign entry_count_cmp = CMP_W'(entry_count_reg);
    assign active_cmp      = (entry_count_cmp < DEPTH_CMP) ? entry_count_cmp : DEPTH_CMP;
    assign index_cmp       = CMP_W'(req.index);
    assign push_ok         = (index_cmp < active_cmp);
    assign fill_go         = start_full_reg && (active_cmp != '0);
    assign fill_end        = (fill_idx_reg == fill_last_reg);
    // a link above the null value only comes from an unwritten entry
    assign link_loaded     = (rd_data_reg > NULL_LINK) ? NULL_LINK : rd_data_reg;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    case (req.operation)
                        OP_POP:
                        begin
                            if (head_ok)
                            begin
                                state_next = ST_POP;
                            end
                        end
                        OP_REINIT:
                        begin
                            if (fill_go)
                            begin
                                state_next = ST_FILL;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_POP:
            begin
                state_next = ST_IDLE;
            end
            ST_FILL:
            begin
                if (fill_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control outputs: handshake and memory ports
    always_comb
    begin
        req_ready = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = fill_idx_reg;
        mem_wdata = fill_end ? NULL_LINK : (LINK_W'(fill_idx_reg) + LINK_W'(1));
        mem_raddr = head_reg[ADDR_W-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = !rsp_valid_reg || rsp_ready;
                if (req_fire && (req.operation == OP_PUSH) && push_ok)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = index_cmp[ADDR_W-1:0];
                    mem_wdata = head_reg;
                end
            end
            ST_FILL:
            begin
                mem_we = 1'b1;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    // datapath: head, fill walk and response
    always_comb
    begin
        head_next      = head_reg;
        fill_idx_next  = fill_idx_reg;
        fill_last_next = fill_last_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;

        if (state_reg == ST_POP)
        begin
            head_next = link_loaded;
        end

        if (state_reg == ST_FILL)
        begin
            fill_idx_next = fill_idx_reg + ADDR_W'(1);
        end

        if (req_fire)
        begin
            rsp_valid_next        = 1'b1;
            rsp_next.popped_index = '0;
            rsp_next.ok           = 1'b0;
            case (req.operation)
                OP_POP:
                begin
                    if (head_ok)
                    begin
                        rsp_next.popped_index = index_of_head(head_reg);
                        rsp_next.ok           = 1'b1;
                    end
                end
                OP_PUSH:
                begin
                    if (push_ok)
                    begin
                        head_next   = LINK_W'(index_cmp);
                        rsp_next.ok = 1'b1;
                    end
                end
                OP_REINIT:
                begin
                    rsp_next.ok = 1'b1;
                    if (fill_go)
                    begin
                        head_next      = '0;
                        fill_idx_next  = '0;
                        fill_last_next = ADDR_W'(active_cmp - CMP_W'(1));
                    end
                    else
                    begin
                        head_next = NULL_LINK;
                    end
                end
                default:
                begin
                    rsp_next.ok = 1'b0;
                end
            endcase
        end
    end

    // link memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= link_mem[mem_raddr];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            head_reg        <= NULL_LINK;
            rsp_valid_reg   <= 1'b0;
            entry_count_reg <= ENTRY_COUNT_RESET;
            start_full_reg  <= START_FULL_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            rsp_valid_reg <= rsp_valid_next;
            if (config_write)
            begin
                case (config_index)
                    CFG_ENTRY_COUNT:
                    begin
                        entry_count_reg <= config_data[ENTRY_COUNT_W-1:0];
                    end
                    CFG_START_FULL:
                    begin
                        start_full_reg <= config_data[0];
                    end
                    default:
                    begin
                        start_full_reg <= start_full_reg;
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        fill_idx_reg  <= fill_idx_next;
        fill_last_reg <= fill_last_next;
        rsp_reg       <= rsp_next;
    end

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// self-checking testbench for index_free_list: directed and random transactions against a predictor
`default_nettype none

module tb;
    import idxfl_pkg::*;

    // operation code outside the defined set, the block must refuse it
    localparam logic [1:0] OP_UNKNOWN = 2'd3;
    // head value that marks an empty list
    localparam logic [INDEX_W:0] NULL_LINK = (INDEX_W+1)'(DEPTH_DEFAULT);
    // cycles without any transaction before the run is declared hung;
    // it must outlast a full-width fill reinit plus the stalls around it
    localparam int QUIET_LIMIT = 5000;
    localparam int TAIL_CYCLES = 20;
    localparam int CFG_SETTLE  = 4;
    localparam int PHASE_ITEMS = 135;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   config_write = 1'b0;
    logic [CFG_INDEX_W-1:0] config_index = '0;
    logic [CFG_DATA_W-1:0]  config_data  = '0;
    logic                   req_valid    = 1'b0;
    logic                   req_ready;
    req_item_t              req          = '0;
    logic                   rsp_valid;
    logic                   rsp_ready    = 1'b0;
    rsp_item_t              rsp;

    // predictor copy of the list: head register, link store, registers
    logic [INDEX_W:0]       fl_head          = NULL_LINK;
    logic [INDEX_W:0]       fl_link [DEPTH_DEFAULT];
    logic [ENTRY_COUNT_W-1:0] cfg_entry_count = ENTRY_COUNT_RESET;
    logic                   cfg_start_full   = START_FULL_RESET;

    // responses still owed by the block, oldest first
    rsp_item_t              pending_rsp [$];
    // indices handed out and not yet returned, used to build legal pushes
    logic [INDEX_W-1:0]     held_idx [$];

    int send_idle_pct  = 0;
    int rsp_stall_pct  = 0;
    int mismatch_count = 0;
    int quiet_cycles   = 0;

    index_free_list #(
        .DEPTH(DEPTH_DEFAULT)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .config_write (config_write),
        .config_index (config_index),
        .config_data  (config_data),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .req          (req),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .rsp          (rsp)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // entries in use: the register value clipped to the link store size
    function automatic int active_entries();
        return (cfg_entry_count < NULL_LINK) ? int'(cfg_entry_count) : int'(NULL_LINK);
    endfunction

    // applies one request to the predicted list and returns its response
    function automatic rsp_item_t free_list_step(req_item_t item);
        rsp_item_t res;
        int        n;
        res = '0;
        n   = active_entries();
        case (item.operation)
            OP_POP:
                // empty pop leaves everything as it was
                if (fl_head < NULL_LINK)
                begin
                    res.popped_index = fl_head[INDEX_W-1:0];
                    fl_head          = fl_link[fl_head[INDEX_W-1:0]];
                    if (fl_head > NULL_LINK)
                        fl_head = NULL_LINK;
                    res.ok = 1'b1;
                end
            OP_PUSH:
                // an index beyond the active count is flagged and dropped
                if (int'(item.index) < n)
                begin
                    fl_link[item.index] = fl_head;
                    fl_head             = {1'b0, item.index};
                    res.ok              = 1'b1;
                end
            OP_REINIT:
            begin
                // empty mode or zero count both leave an empty list
                if (!cfg_start_full || n == 0)
                    fl_head = NULL_LINK;
                else
                begin
                    for (int i = 0; i + 1 < n; i++)
                        fl_link[i] = (INDEX_W+1)'(i + 1);
                    fl_link[n-1] = NULL_LINK;
                    fl_head      = '0;
                end
                res.ok = 1'b1;
            end
            default:
                ;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // response side: random stall, checker, watchdog
    // ------------------------------------------------------------------

    always @(negedge clk)
        rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);

    // every accepted response is matched against the oldest prediction
    always @(posedge clk)
    begin : check_rsp
        rsp_item_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("unexpected transaction: popped_index %0d ok %0b",
                       rsp.popped_index, rsp.ok);
                mismatch_count++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp.popped_index !== want.popped_index)
                begin
                    $error("popped_index: expected %0d, got %0d",
                           want.popped_index, rsp.popped_index);
                    mismatch_count++;
                end
                if (rsp.ok !== want.ok)
                begin
                    $error("ok: expected %0b, got %0b", want.ok, rsp.ok);
                    mismatch_count++;
                end
            end
        end
    end

    // counts cycles without a transaction on either channel
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------

    // presents one request, waits for the handshake and records the prediction
    task automatic send_req(logic [1:0] op, logic [INDEX_W-1:0] idx);
        req_item_t item;
        rsp_item_t res;
        item.operation = op_t'(op);
        item.index     = idx;
        @(negedge clk);
        // random sender gaps, valid only drops between transactions
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (!req_ready);
        res = free_list_step(item);
        pending_rsp.push_back(res);
        if (op == OP_POP && res.ok)
            held_idx.push_back(res.popped_index);
        if (op == OP_REINIT)
            held_idx.delete();
    endtask

    // stops sending and waits until every owed response has come back
    task automatic drain_pending();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] ri, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        config_write <= 1'b1;
        config_index <= ri;
        config_data  <= val;
        @(negedge clk);
        config_write <= 1'b0;
        if (ri == CFG_ENTRY_COUNT)
            cfg_entry_count = val;
        else
            cfg_start_full = val[0];
    endtask

    // registers change only once the block has gone quiet
    task automatic set_config(logic [CFG_DATA_W-1:0] count_val, logic full_val);
        drain_pending();
        // a fill walk may still be running after its response has gone
        while (!req_ready)
            @(posedge clk);
        repeat (CFG_SETTLE) @(posedge clk);
        write_reg(CFG_ENTRY_COUNT, count_val);
        write_reg(CFG_START_FULL, CFG_DATA_W'(full_val));
    endtask

    // mostly pops and pushes of indices that were handed out, some noise
    task automatic send_random_item();
        int                 pick;
        int                 k;
        logic [INDEX_W-1:0] idx;
        pick = $urandom_range(0, 99);
        idx  = INDEX_W'($urandom_range(0, 255));
        if (pick < 45)
            send_req(OP_POP, idx);
        else if (pick < 85)
        begin
            if (held_idx.size() != 0)
            begin
                k   = $urandom_range(0, held_idx.size() - 1);
                idx = held_idx[k];
                held_idx.delete(k);
            end
            else if (active_entries() != 0)
                idx = INDEX_W'($urandom_range(0, active_entries() - 1));
            send_req(OP_PUSH, idx);
        end
        else if (pick < 93)
            send_req(OP_PUSH, idx);
        else if (pick < 97)
            send_req(OP_UNKNOWN, idx);
        else
            send_req(OP_REINIT, idx);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset leaves an empty list, a push must seed it
    task automatic test_empty_after_reset();
        send_req(OP_POP, 8'd0);
        send_req(OP_PUSH, 8'd0);
        send_req(OP_POP, 8'd0);
        send_req(OP_POP, 8'd0);
    endtask

    // full-width fill, highest index and an undefined operation
    task automatic test_index_extremes();
        send_req(OP_REINIT, 8'd0);
        send_req(OP_PUSH, 8'd255);
        send_req(OP_POP, 8'd255);
        send_req(OP_POP, 8'd0);
        send_req(OP_POP, 8'd0);
        send_req(OP_UNKNOWN, 8'd255);
    endtask

    // shrinking the count keeps listed indices but refuses them on push
    task automatic test_count_change();
        set_config(9'd3, 1'b1);
        send_req(OP_REINIT, 8'd0);
        send_req(OP_POP, 8'd0);
        send_req(OP_POP, 8'd0);
        drain_pending();
        repeat (CFG_SETTLE) @(posedge clk);
        write_reg(CFG_ENTRY_COUNT, 9'd1);
        send_req(OP_POP, 8'd0);
        send_req(OP_POP, 8'd0);
        send_req(OP_PUSH, 8'd2);
        send_req(OP_PUSH, 8'd0);
    endtask

    // zero count fills nothing; empty mode with the widest count
    task automatic test_zero_count_and_empty_mode();
        set_config(9'd0, 1'b1);
        send_req(OP_REINIT, 8'd0);
        send_req(OP_POP, 8'd0);
        send_req(OP_PUSH, 8'd0);
        set_config(9'd511, 1'b0);
        send_req(OP_REINIT, 8'd0);
        send_req(OP_POP, 8'd0);
        send_req(OP_PUSH, 8'd255);
        send_req(OP_POP, 8'd0);
    endtask

    // one random phase: new setting, fresh list, a drain halfway through
    task automatic test_random_phase(logic [CFG_DATA_W-1:0] count_val, logic full_val,
                                     int idle_mode);
        set_config(count_val, full_val);
        case (idle_mode)
            0:       begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1:       begin send_idle_pct = 83; rsp_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  rsp_stall_pct = 83; end
            default: begin send_idle_pct = 27; rsp_stall_pct = 27; end
        endcase
        send_req(OP_REINIT, INDEX_W'($urandom_range(0, 255)));
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            // sender holds off until the block has answered everything
            if (i == PHASE_ITEMS / 2)
                drain_pending();
            send_random_item();
        end
    endtask

    initial
    begin
        // reset held at the start, released away from the rising edge
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_after_reset();
        test_index_extremes();
        test_count_change();
        test_zero_count_and_empty_mode();

        // small counts dominate so that fill reinits stay cheap
        test_random_phase(9'd256, 1'b1, 0);
        test_random_phase(9'd16,  1'b1, 1);
        test_random_phase(9'd2,   1'b1, 2);
        test_random_phase(9'd511, 1'b0, 3);
        test_random_phase(9'd1,   1'b1, 0);
        test_random_phase(9'd40,  1'b0, 1);
        test_random_phase(9'd5,   1'b1, 2);
        test_random_phase(9'd200, 1'b1, 3);

        drain_pending();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_rsp.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

// File: index_free_list.f
rtl/idxfl_pkg.sv
rtl/index_free_list.sv
tb/sv/tb.sv
